// ===== rtl/core/cbre_pkg.sv =====
package cbre_pkg;

    // Sizes
    localparam int MAX_CAPACITY = 15;
    localparam int LOAD_CLASSES = MAX_CAPACITY + 1;
    localparam int CLASS_W      = $clog2(LOAD_CLASSES);
    localparam int AGE_DEPTH    = 64;
    localparam int AGE_W        = $clog2(AGE_DEPTH);
    localparam int HIST_W       = 17;
    localparam int CNT_W        = 32;
    localparam int CUM_W        = HIST_W + CLASS_W;
    localparam int BIN_W        = 16;
    localparam int CAP_W        = 4;
    localparam int ARR_W        = 16;
    localparam int STATUS_W     = 3;
    localparam int LCLASS_W     = 4;
    localparam int WAIT_W       = 7;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [HIST_W-1:0] HIST_MAX = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

    // Reset values of the configuration registers
    localparam logic [BIN_W-1:0] NUM_BINS_RST = BIN_W'(1000);
    localparam logic [CAP_W-1:0] CAPACITY_RST = CAP_W'(4);
    localparam logic [ARR_W-1:0] ARRIVALS_RST = ARR_W'(900);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BINS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ARRIVALS = CFG_IDX_W'(2);

    // Operations
    localparam logic OP_ROUND = 1'b0;
    localparam logic OP_THROW = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ROUND   = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_PLACED  = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_FULL    = STATUS_W'(2);
    localparam logic [STATUS_W-1:0] ST_INVALID = STATUS_W'(3);
    localparam logic [STATUS_W-1:0] ST_NOTHING = STATUS_W'(4);

    // Shared unit operations
    typedef logic [1:0] alu_op_t;
    localparam alu_op_t ALU_ADD32 = 2'd0;  // saturating at 2^32-1
    localparam alu_op_t ALU_ADD17 = 2'd1;  // saturating at 2^17-1
    localparam alu_op_t ALU_DEC   = 2'd2;  // decrement, floor at zero

    typedef struct packed {
        logic              operation;
        logic [BIN_W-1:0]  random_pick;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LCLASS_W-1:0] load_class;
        logic [WAIT_W-1:0]   wait_rounds;
        logic [CNT_W-1:0]    throws_left;
        logic                round_done;
    } result_t;

    // Write request to the age memory
    typedef struct packed {
        logic             en;
        logic [AGE_W-1:0] addr;
        logic [CNT_W-1:0] data;
    } age_wr_t;

endpackage

// ===== rtl/core/cbre_alu.sv =====
module cbre_alu (
    input  cbre_pkg::alu_op_t                op,
    input  logic [cbre_pkg::CNT_W-1:0]       a,
    input  logic [cbre_pkg::CNT_W-1:0]       b,
    output logic [cbre_pkg::CNT_W-1:0]       y
);
    import cbre_pkg::*;

    logic [CNT_W:0] sum;

    assign sum = {1'b0, a} + {1'b0, b};

    always_comb
    begin
        unique case (op)
            ALU_ADD32:
            begin
                y = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
            end
            ALU_ADD17:
            begin
                y = (sum > (CNT_W+1)'(HIST_MAX)) ? CNT_W'(HIST_MAX) : sum[CNT_W-1:0];
            end
            ALU_DEC:
            begin
                y = (a == '0) ? '0 : a - 1'b1;
            end
            default:
            begin
                y = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/cbre_age_mem.sv =====
module cbre_age_mem (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [cbre_pkg::AGE_W-1:0]    rd_addr,
    output logic [cbre_pkg::CNT_W-1:0]    rd_data,
    input  cbre_pkg::age_wr_t             wr
);
    import cbre_pkg::*;

    logic [CNT_W-1:0]     mem [AGE_DEPTH];
    logic [AGE_DEPTH-1:0] vld_reg;
    logic [CNT_W-1:0]     q_reg;
    logic                 q_vld_reg;

    // Storage: no reset, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        q_reg <= mem[rd_addr];
    end

    // Entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            q_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            q_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = q_vld_reg ? q_reg : '0;

endmodule

// ===== rtl/core/capacitated_bins_round_engine.sv =====
// Capacitated balls-into-bins round engine.
// Channels: item (valid/ready) carries one word {operation, random_pick};
// result (valid/ready) returns exactly one word per item; cfg (valid/ready)
// writes num_bins (0), bin_capacity (1) or arrivals_per_round (2). cfg is
// always ready and must only be used while the engine is idle.
// A round start does one read of the age memory per cycle while it is shifted
// and summed, plus a closing step, then the emit step loads the result
// register. A throw does up to AGE_DEPTH - 1 memory reads to find the next
// non-empty age, walks one load class per cycle (up to 16), then the
// single-step updates (DECT, DECA, HDEC, HINC, WDEC), all
// through one shared saturating add/decrement unit.
// The engine holds one item at a time; item_ready is high only when idle.
// A finished word waits in the result register; if the receiver stalls, the
// engine holds its next result until the register frees and takes no item.
// Reset: configuration returns to 1000 bins, capacity 4, 900 arrivals; all
// bins empty, no balls waiting, no throws pending. No clearing pass needed.
// Writing num_bins empties every bin.
module capacitated_bins_round_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  cbre_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output cbre_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cbre_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cbre_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import cbre_pkg::*;

    // Sequencer states
    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
    localparam logic [ST_W-1:0] S_RS     = 4'd1;   // age shift sweep
    localparam logic [ST_W-1:0] S_RS_FIN = 4'd2;   // arrivals at age zero
    localparam logic [ST_W-1:0] S_SCAN   = 4'd3;   // look for next non-empty age
    localparam logic [ST_W-1:0] S_CHECK  = 4'd4;
    localparam logic [ST_W-1:0] S_WALK   = 4'd5;   // cumulative load walk
    localparam logic [ST_W-1:0] S_DECT   = 4'd6;
    localparam logic [ST_W-1:0] S_DECA   = 4'd7;
    localparam logic [ST_W-1:0] S_HDEC   = 4'd8;
    localparam logic [ST_W-1:0] S_HINC   = 4'd9;
    localparam logic [ST_W-1:0] S_WDEC   = 4'd10;
    localparam logic [ST_W-1:0] S_EMIT   = 4'd11;

    localparam logic [AGE_W-1:0]   AGE_LAST   = AGE_W'(AGE_DEPTH - 1);
    localparam logic [AGE_W-1:0]   AGE_PENULT = AGE_W'(AGE_DEPTH - 2);
    localparam logic [CLASS_W-1:0] CLASS_LAST = CLASS_W'(LOAD_CLASSES - 1);

    // Control state
    logic [ST_W-1:0]   state_reg, state_next;
    logic [BIN_W-1:0]  num_bins_reg, num_bins_next;
    logic [CAP_W-1:0]  capacity_reg, capacity_next;
    logic [ARR_W-1:0]  arrivals_reg, arrivals_next;
    logic [HIST_W-1:0] hist_reg [LOAD_CLASSES];
    logic [HIST_W-1:0] hist_next [LOAD_CLASSES];
    logic [AGE_W-1:0]  cursor_reg, cursor_next;
    logic [CNT_W-1:0]  at_age_reg, at_age_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic              result_valid_reg, result_valid_next;

    // Working registers
    logic [CNT_W-1:0]    hold_reg, hold_next;
    logic [AGE_W-1:0]    sweep_reg, sweep_next;
    logic [CLASS_W-1:0]  k_reg, k_next;
    logic [CUM_W-1:0]    cum_reg, cum_next;
    logic [BIN_W-1:0]    pick_reg, pick_next;
    logic [STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic [LCLASS_W-1:0] pend_class_reg, pend_class_next;
    logic [WAIT_W-1:0]   pend_wait_reg, pend_wait_next;
    result_t             result_reg, result_next;

    // Shared unit and memory hookup
    alu_op_t          alu_op;
    logic [CNT_W-1:0] alu_a;
    logic [CNT_W-1:0] alu_b;
    logic [CNT_W-1:0] alu_y;
    logic [AGE_W-1:0] mem_rd_addr;
    logic [CNT_W-1:0] mem_rd_data;
    age_wr_t          mem_wr;

    logic [CLASS_W-1:0] cap_eff;
    logic [CLASS_W-1:0] k_inc;
    logic               result_load;

    cbre_alu u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    cbre_age_mem u_age_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr      (mem_wr)
    );

    assign cap_eff = (capacity_reg > CAP_W'(MAX_CAPACITY)) ? CLASS_W'(MAX_CAPACITY)
                                                           : CLASS_W'(capacity_reg);
    assign k_inc   = k_reg + 1'b1;

    assign item_ready   = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        state_next       = state_reg;
        num_bins_next    = num_bins_reg;
        capacity_next    = capacity_reg;
        arrivals_next    = arrivals_reg;
        hist_next        = hist_reg;
        cursor_next      = cursor_reg;
        at_age_next      = at_age_reg;
        total_next       = total_reg;
        hold_next        = hold_reg;
        sweep_next       = sweep_reg;
        k_next           = k_reg;
        cum_next         = cum_reg;
        pick_next        = pick_reg;
        pend_status_next = pend_status_reg;
        pend_class_next  = pend_class_reg;
        pend_wait_next   = pend_wait_reg;
        alu_op           = ALU_ADD32;
        alu_a            = '0;
        alu_b            = '0;
        mem_rd_addr      = cursor_reg;
        mem_wr           = '0;
        result_load      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    pick_next       = item.random_pick;
                    pend_class_next = '0;
                    pend_wait_next  = '0;
                    if (item.operation == OP_ROUND)
                    begin
                        mem_rd_addr = AGE_LAST;
                        sweep_next  = AGE_LAST;
                        state_next  = S_RS;
                    end
                    else if (total_reg == '0)
                    begin
                        pend_status_next = ST_NOTHING;
                        state_next       = S_EMIT;
                    end
                    else if (at_age_reg == '0 && cursor_reg != '0)
                    begin
                        mem_rd_addr = cursor_reg - 1'b1;
                        cursor_next = cursor_reg - 1'b1;
                        state_next  = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end

            S_RS:
            begin
                if (sweep_reg == AGE_LAST)
                begin
                    // oldest count held; bins drop one ball each
                    hold_next = mem_rd_data;
                    alu_op    = ALU_ADD17;
                    alu_a     = CNT_W'(hist_reg[0]);
                    alu_b     = CNT_W'(hist_reg[1]);
                    hist_next[0] = alu_y[HIST_W-1:0];
                    for (int i = 1; i < LOAD_CLASSES - 1; i++)
                    begin
                        hist_next[i] = hist_reg[i+1];
                    end
                    hist_next[LOAD_CLASSES-1] = '0;
                end
                else if (sweep_reg == AGE_PENULT)
                begin
                    // oldest age saturates
                    alu_a       = hold_reg;
                    alu_b       = mem_rd_data;
                    mem_wr      = '{en: 1'b1, addr: AGE_LAST, data: alu_y};
                    at_age_next = alu_y;
                    total_next  = alu_y;
                end
                else
                begin
                    alu_a      = total_reg;
                    alu_b      = mem_rd_data;
                    mem_wr     = '{en: 1'b1, addr: sweep_reg + 1'b1, data: mem_rd_data};
                    total_next = alu_y;
                end

                if (sweep_reg != '0)
                begin
                    mem_rd_addr = sweep_reg - 1'b1;
                    sweep_next  = sweep_reg - 1'b1;
                end
                else
                begin
                    state_next = S_RS_FIN;
                end
            end

            S_RS_FIN:
            begin
                alu_a            = total_reg;
                alu_b            = CNT_W'(arrivals_reg);
                mem_wr           = '{en: 1'b1, addr: '0, data: CNT_W'(arrivals_reg)};
                total_next       = alu_y;
                cursor_next      = AGE_LAST;
                pend_status_next = ST_ROUND;
                state_next       = S_EMIT;
            end

            S_SCAN:
            begin
                at_age_next = mem_rd_data;
                if (mem_rd_data == '0 && cursor_reg != '0)
                begin
                    mem_rd_addr = cursor_reg - 1'b1;
                    cursor_next = cursor_reg - 1'b1;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (at_age_reg == '0)
                begin
                    total_next       = '0;
                    pend_status_next = ST_NOTHING;
                    state_next       = S_EMIT;
                end
                else if (pick_reg == '0 || pick_reg > num_bins_reg)
                begin
                    pend_status_next = ST_INVALID;
                    state_next       = S_EMIT;
                end
                else
                begin
                    k_next     = '0;
                    cum_next   = '0;
                    state_next = S_WALK;
                end
            end

            S_WALK:
            begin
                alu_a = CNT_W'(cum_reg);
                alu_b = CNT_W'(hist_reg[k_reg]);
                if (alu_y[CUM_W-1:0] >= CUM_W'(pick_reg))
                begin
                    state_next = S_DECT;
                end
                else if (k_reg == CLASS_LAST)
                begin
                    pend_status_next = ST_INVALID;
                    state_next       = S_EMIT;
                end
                else
                begin
                    k_next   = k_inc;
                    cum_next = alu_y[CUM_W-1:0];
                end
            end

            S_DECT:
            begin
                alu_op     = ALU_DEC;
                alu_a      = total_reg;
                total_next = alu_y;
                state_next = S_DECA;
            end

            S_DECA:
            begin
                alu_op      = ALU_DEC;
                alu_a       = at_age_reg;
                at_age_next = alu_y;
                if (k_reg >= cap_eff)
                begin
                    pend_status_next = ST_FULL;
                    pend_class_next  = LCLASS_W'(k_reg);
                    state_next       = S_EMIT;
                end
                else
                begin
                    state_next = S_HDEC;
                end
            end

            S_HDEC:
            begin
                alu_op           = ALU_DEC;
                alu_a            = CNT_W'(hist_reg[k_reg]);
                hist_next[k_reg] = alu_y[HIST_W-1:0];
                state_next       = S_HINC;
            end

            S_HINC:
            begin
                // read of the ball's age count goes out here (cursor address)
                alu_op           = ALU_ADD17;
                alu_a            = CNT_W'(hist_reg[k_inc]);
                alu_b            = CNT_W'(1);
                hist_next[k_inc] = alu_y[HIST_W-1:0];
                state_next       = S_WDEC;
            end

            S_WDEC:
            begin
                alu_op           = ALU_DEC;
                alu_a            = mem_rd_data;
                mem_wr           = '{en: 1'b1, addr: cursor_reg, data: alu_y};
                pend_status_next = ST_PLACED;
                pend_class_next  = LCLASS_W'(k_reg);
                pend_wait_next   = WAIT_W'(cursor_reg) + WAIT_W'(k_reg);
                state_next       = S_EMIT;
            end

            S_EMIT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_load = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Configuration writes must arrive only while idle; the block does not enforce it
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_NUM_BINS:
                begin
                    num_bins_next = cfg_data;
                    for (int i = 0; i < LOAD_CLASSES; i++)
                    begin
                        hist_next[i] = '0;
                    end
                    hist_next[0] = HIST_W'(cfg_data);
                end
                CFG_CAPACITY:
                begin
                    capacity_next = cfg_data[CAP_W-1:0];
                end
                CFG_ARRIVALS:
                begin
                    arrivals_next = cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Output register
    always_comb
    begin
        result_next = result_reg;
        if (result_load)
        begin
            result_next.status      = pend_status_reg;
            result_next.load_class  = pend_class_reg;
            result_next.wait_rounds = pend_wait_reg;
            result_next.throws_left = total_reg;
            result_next.round_done  = (total_reg == '0);
        end

        if (result_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            num_bins_reg     <= NUM_BINS_RST;
            capacity_reg     <= CAPACITY_RST;
            arrivals_reg     <= ARRIVALS_RST;
            for (int i = 1; i < LOAD_CLASSES; i++)
            begin
                hist_reg[i] <= '0;
            end
            hist_reg[0]      <= HIST_W'(NUM_BINS_RST);
            cursor_reg       <= '0;
            at_age_reg       <= '0;
            total_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            num_bins_reg     <= num_bins_next;
            capacity_reg     <= capacity_next;
            arrivals_reg     <= arrivals_next;
            hist_reg         <= hist_next;
            cursor_reg       <= cursor_next;
            at_age_reg       <= at_age_next;
            total_reg        <= total_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg        <= hold_next;
        sweep_reg       <= sweep_next;
        k_reg           <= k_next;
        cum_reg         <= cum_next;
        pick_reg        <= pick_next;
        pend_status_reg <= pend_status_next;
        pend_class_reg  <= pend_class_next;
        pend_wait_reg   <= pend_wait_next;
        result_reg      <= result_next;
    end

`ifndef NO_ASSERTIONS
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> (state_reg != S_IDLE))
        else $error("engine stayed idle after taking a word");

    a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !item_valid) |=>
            ($stable(cursor_reg) && $stable(total_reg) && $stable(at_age_reg)))
        else $error("throw bookkeeping moved while idle");

    a_throw_consumes_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECT) |=> (total_reg == $past(total_reg) - 1'b1))
        else $error("consumed throw did not take exactly one from the count");

    a_place_below_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HDEC) |-> (k_reg < cap_eff))
        else $error("ball placed into a full bin");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) == S_EMIT))
        else $error("result word appeared outside the emit step");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    import cbre_pkg::*;

    // Register index that maps to nothing; a write to it must leave all settings alone.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

    // Closing quiet time and the length of the deliberate receiver hold-off, in cycles.
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_AT_WORD = 900;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_ready;
    item_t                 item         = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    result_t               result;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    capacitated_bins_round_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the engine: settings, load histogram, waiting balls
    // by age and the throw bookkeeping of the current round.
    // ------------------------------------------------------------------
    logic [BIN_W-1:0]  cfg_bins;
    logic [CAP_W-1:0]  cfg_cap;
    logic [ARR_W-1:0]  cfg_arrivals;
    logic [HIST_W-1:0] bins_by_load [LOAD_CLASSES];
    logic [CNT_W-1:0]  balls_by_age [AGE_DEPTH];
    logic [AGE_W-1:0]  age_cursor;
    logic [CNT_W-1:0]  throws_at_age;
    logic [CNT_W-1:0]  throws_total;

    item_t   queued_items [$];   // words waiting to be offered
    result_t outcomes_due [$];   // predicted result words, oldest first

    int  idle_pct    = 31;       // chance in a hundred that either side idles
    int  words_taken = 0;
    bit  failed      = 1'b0;

    function automatic logic [HIST_W-1:0] sat_hist(input logic [HIST_W-1:0] a, b);
        logic [HIST_W:0] s;
        s = a + b;
        return s[HIST_W] ? HIST_MAX : s[HIST_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] a, b);
        logic [CNT_W:0] s;
        s = a + b;
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    // All bins empty: every bin sits in load class zero.
    task automatic empty_bins();
        for (int i = 0; i < LOAD_CLASSES; i++)
            bins_by_load[i] = '0;
        bins_by_load[0] = HIST_W'(cfg_bins);
    endtask

    task automatic reset_shadow();
        cfg_bins     = NUM_BINS_RST;
        cfg_cap      = CAPACITY_RST;
        cfg_arrivals = ARRIVALS_RST;
        empty_bins();
        for (int i = 0; i < AGE_DEPTH; i++)
            balls_by_age[i] = '0;
        age_cursor    = '0;
        throws_at_age = '0;
        throws_total  = '0;
    endtask

    // Applies one word to the shadow state and gives the result word it causes.
    task automatic play_item(input item_t w, output result_t r);
        logic [CUM_W-1:0]    cum;
        logic [CNT_W-1:0]    sum;
        logic [STATUS_W-1:0] st;
        logic [LCLASS_W-1:0] cls;
        logic [WAIT_W-1:0]   wt;
        int                  hit;
        bit                  found;
        st  = ST_ROUND;
        cls = '0;
        wt  = '0;
        hit = 0;
        if (w.operation == OP_ROUND)
        begin
            // every loaded bin loses one ball
            bins_by_load[0] = sat_hist(bins_by_load[0], bins_by_load[1]);
            for (int i = 1; i < MAX_CAPACITY; i++)
                bins_by_load[i] = bins_by_load[i + 1];
            bins_by_load[MAX_CAPACITY] = '0;
            // balls age by one round; the oldest slot keeps its own and saturates
            balls_by_age[AGE_DEPTH - 1] = sat_count(balls_by_age[AGE_DEPTH - 1],
                                                    balls_by_age[AGE_DEPTH - 2]);
            for (int i = AGE_DEPTH - 2; i > 0; i--)
                balls_by_age[i] = balls_by_age[i - 1];
            balls_by_age[0] = CNT_W'(cfg_arrivals);
            sum = '0;
            for (int i = 0; i < AGE_DEPTH; i++)
                sum = sat_count(sum, balls_by_age[i]);
            throws_total  = sum;
            age_cursor    = AGE_W'(AGE_DEPTH - 1);
            throws_at_age = balls_by_age[AGE_DEPTH - 1];
        end
        else if (throws_total == '0)
            st = ST_NOTHING;
        else
        begin
            // oldest balls first: step down to the next age that still has throws
            while (throws_at_age == '0 && age_cursor != '0)
            begin
                age_cursor--;
                throws_at_age = balls_by_age[age_cursor];
            end
            if (throws_at_age == '0)
            begin
                throws_total = '0;
                st = ST_NOTHING;
            end
            else if (w.random_pick == '0 || w.random_pick > cfg_bins)
                st = ST_INVALID;
            else
            begin
                cum   = '0;
                found = 1'b0;
                for (int i = 0; i < LOAD_CLASSES; i++)
                begin
                    if (!found)
                    begin
                        cum = cum + CUM_W'(bins_by_load[i]);
                        if (cum >= CUM_W'(w.random_pick))
                        begin
                            found = 1'b1;
                            hit   = i;
                        end
                    end
                end
                if (!found)
                    st = ST_INVALID;
                else
                begin
                    // the throw is used up whether or not the ball lands
                    throws_at_age--;
                    throws_total--;
                    cls = LCLASS_W'(hit);
                    // capacity is four bits wide, so it never exceeds MAX_CAPACITY
                    if (hit >= int'(cfg_cap))
                        st = ST_FULL;
                    else
                    begin
                        if (bins_by_load[hit] != '0)
                            bins_by_load[hit]--;
                        bins_by_load[hit + 1] = sat_hist(bins_by_load[hit + 1], HIST_W'(1));
                        if (balls_by_age[age_cursor] != '0)
                            balls_by_age[age_cursor]--;
                        st = ST_PLACED;
                        wt = WAIT_W'(int'(age_cursor) + hit);
                    end
                end
            end
        end
        r.status      = st;
        r.load_class  = cls;
        r.wait_rounds = wt;
        r.throws_left = throws_total;
        r.round_done  = (throws_total == '0);
    endtask

    // ------------------------------------------------------------------
    // Item driver: offers queued words, idles at random between them and
    // keeps a word steady until the engine takes it.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        logic    offer;
        result_t due;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else
        begin
            offer = item_valid;
            if (item_valid && item_ready)
            begin
                play_item(item, due);
                outcomes_due.push_back(due);
                offer = 1'b0;
            end
            if (!offer && queued_items.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                item  <= queued_items.pop_front();
                offer = 1'b1;
            end
            item_valid <= offer;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: checks each accepted word against the oldest
    // prediction. Ready idles at random; once, after HOLD_AT_WORD words,
    // it is held low for a long stretch so the engine backs up and stops
    // taking items.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : watch_results
        result_t want;
        int      hold_left;
        bit      hold_done;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            hold_left    = 0;
            hold_done    = 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                words_taken++;
                if (outcomes_due.size() == 0)
                begin
                    $error("result word with none outstanding: status %0d", result.status);
                    failed = 1'b1;
                end
                else
                begin
                    want = outcomes_due.pop_front();
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, result.status);
                        failed = 1'b1;
                    end
                    if (result.load_class !== want.load_class)
                    begin
                        $error("load_class: expected %0d, got %0d",
                               want.load_class, result.load_class);
                        failed = 1'b1;
                    end
                    if (result.wait_rounds !== want.wait_rounds)
                    begin
                        $error("wait_rounds: expected %0d, got %0d",
                               want.wait_rounds, result.wait_rounds);
                        failed = 1'b1;
                    end
                    if (result.throws_left !== want.throws_left)
                    begin
                        $error("throws_left: expected %0d, got %0d",
                               want.throws_left, result.throws_left);
                        failed = 1'b1;
                    end
                    if (result.round_done !== want.round_done)
                    begin
                        $error("round_done: expected %0d, got %0d",
                               want.round_done, result.round_done);
                        failed = 1'b1;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (!hold_done && words_taken == HOLD_AT_WORD)
            begin
                hold_left    = HOLD_CYCLES;
                hold_done    = 1'b1;
                result_ready <= 1'b0;
            end
            else
                result_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_item(input logic op, input logic [BIN_W-1:0] pick);
        item_t w;
        w.operation   = op;
        w.random_pick = pick;
        queued_items.push_back(w);
    endtask

    // Config writes go only through here; the shadow copy follows on acceptance.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_NUM_BINS:
            begin
                cfg_bins = BIN_W'(data);
                empty_bins();
            end
            CFG_CAPACITY: cfg_cap      = CAP_W'(data);
            CFG_ARRIVALS: cfg_arrivals = ARR_W'(data);
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Engine is idle once every word has gone in and every result has come back.
    // Sampled at the falling edge, when the driver and monitor have settled.
    task automatic settle();
        while (!(queued_items.size() == 0 && !item_valid && outcomes_due.size() == 0))
            @(negedge clk);
    endtask

    // Mostly sensible throws: picks within range, with zero, out-of-range and
    // fully random picks mixed in. Round starts carry random pick bits.
    task automatic queue_items(input int count, input int round_pct);
        item_t w;
        int    r;
        for (int n = 0; n < count; n++)
        begin
            w.random_pick = BIN_W'($urandom_range(65535));
            if ($urandom_range(99) < round_pct)
                w.operation = OP_ROUND;
            else
            begin
                w.operation = OP_THROW;
                r = $urandom_range(99);
                if (r < 80 && cfg_bins != '0)
                    w.random_pick = BIN_W'($urandom_range(cfg_bins, 1));
                else if (r < 87)
                    w.random_pick = '0;
                else if (r < 94 && cfg_bins != '1)
                    w.random_pick = BIN_W'($urandom_range(65535, cfg_bins + 1));
            end
            queued_items.push_back(w);
        end
    endtask

    initial
    begin
        int round_mix [8];
        int r;
        round_mix = '{10, 5, 95, 3, 20, 50, 8, 15};
        reset_shadow();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: a throw before any round, then range edges of the pick
        // and a round start in the middle of a round.
        push_item(OP_THROW, 16'd5);
        push_item(OP_ROUND, 16'd0);
        push_item(OP_THROW, 16'd0);
        push_item(OP_THROW, 16'd1000);
        push_item(OP_THROW, 16'd1001);
        push_item(OP_THROW, 16'hFFFF);
        push_item(OP_THROW, 16'd1);
        push_item(OP_ROUND, 16'hFFFF);
        push_item(OP_THROW, 16'd500);

        // Two bins holding one ball each: placement, then a full bin, then the
        // round start draining the loads again.
        settle();
        write_register(CFG_NUM_BINS, 16'd2);
        write_register(CFG_CAPACITY, 16'd1);
        write_register(CFG_ARRIVALS, 16'd3);
        push_item(OP_ROUND, 16'd0);
        push_item(OP_THROW, 16'd1);
        push_item(OP_THROW, 16'd1);
        push_item(OP_THROW, 16'd2);
        push_item(OP_ROUND, 16'd0);
        push_item(OP_THROW, 16'd2);
        push_item(OP_THROW, 16'd3);

        // Capacity zero (upper data bits set, must be ignored) and the spare index.
        settle();
        write_register(CFG_CAPACITY, 16'hFFF0);
        write_register(CFG_SPARE, CFG_DATA_W'($urandom_range(65535)));
        push_item(OP_THROW, 16'd1);
        push_item(OP_THROW, 16'd2);

        // No bins at all: every pick is out of range.
        settle();
        write_register(CFG_NUM_BINS, 16'd0);
        push_item(OP_ROUND, 16'd0);
        push_item(OP_THROW, 16'd1);
        push_item(OP_THROW, 16'd0);

        // Largest settings throughout.
        settle();
        write_register(CFG_NUM_BINS, 16'hFFFF);
        write_register(CFG_CAPACITY, 16'd15);
        write_register(CFG_ARRIVALS, 16'hFFFF);
        push_item(OP_ROUND, 16'd0);
        push_item(OP_THROW, 16'hFFFF);
        push_item(OP_THROW, 16'h8000);
        push_item(OP_THROW, 16'd1);

        // Random phases with fresh settings each time. Phase 2 is almost all round
        // starts, so the waiting balls pile up in the oldest age slot; phase 4 runs
        // with no idling on either side.
        for (int ph = 0; ph < 8; ph++)
        begin
            settle();
            idle_pct = (ph == 4) ? 0 : 31;
            if (ph == 0 || (ph != 2 && $urandom_range(3) != 0))
            begin
                r = $urandom_range(9);
                if (r < 6)
                    write_register(CFG_NUM_BINS, CFG_DATA_W'($urandom_range(24, 1)));
                else if (r < 8)
                    write_register(CFG_NUM_BINS, CFG_DATA_W'($urandom_range(3000, 25)));
                else if (r < 9)
                    write_register(CFG_NUM_BINS, ($urandom_range(1)) ? 16'hFFFF : 16'd1);
                else
                    write_register(CFG_NUM_BINS, CFG_DATA_W'($urandom_range(65535)));
            end
            write_register(CFG_CAPACITY, CFG_DATA_W'($urandom_range(65535)));
            r = $urandom_range(9);
            if (ph == 2)
                write_register(CFG_ARRIVALS, CFG_DATA_W'($urandom_range(5, 1)));
            else if (r < 7)
                write_register(CFG_ARRIVALS, CFG_DATA_W'($urandom_range(12)));
            else if (r < 8)
                write_register(CFG_ARRIVALS, 16'd0);
            else if (r < 9)
                write_register(CFG_ARRIVALS, 16'hFFFF);
            else
                write_register(CFG_ARRIVALS, CFG_DATA_W'($urandom_range(65535)));
            queue_items(241, round_mix[ph]);
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, including the long hold-off.
    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/cbre_pkg.sv
rtl/core/cbre_alu.sv
rtl/core/cbre_age_mem.sv
rtl/core/capacitated_bins_round_engine.sv
tb/testbench.sv
